[rtl/quaternion_multiply_normalize_assert.svh]
// Assertion macros shared by the quaternion product block.
`ifndef QUATERNION_MULTIPLY_NORMALIZE_ASSERT_SVH
`define QUATERNION_MULTIPLY_NORMALIZE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define QMN_ASSERT_IMPLY(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (conseq)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define QMN_ASSERT_NEXT(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error(msg);

`endif

[rtl/qmn_pkg.sv]
// Shared types and constants of the quaternion product block.
package qmn_pkg;

   // Component layout: i, j, k, then the scalar part.
   localparam int unsigned NUM_COMP  = 4;
   localparam int unsigned COMP_I    = 0;
   localparam int unsigned COMP_J    = 1;
   localparam int unsigned COMP_K    = 2;
   localparam int unsigned COMP_REAL = 3;
   localparam int unsigned COMP_W    = 16;

   // Data path widths.
   localparam int unsigned PROD16_W = 32;  // one 16x16 product
   localparam int unsigned SUM_W    = 34;  // signed product component
   localparam int unsigned ABS_W    = 33;  // its magnitude, at most 2^32
   localparam int unsigned NORM_W   = 31;  // normalized magnitude, top bit at 30
   localparam int unsigned TOP_W    = 6;
   localparam int unsigned AMT_W    = 5;
   localparam int unsigned SQ_W     = 62;
   localparam int unsigned M_W      = 32;  // squared length, upper word
   localparam int unsigned DIFF_W   = 33;
   localparam int unsigned T_W      = 32;
   localparam int unsigned Y_W      = 34;  // reciprocal root estimate
   localparam int unsigned Q_W      = 34;
   localparam int unsigned E_W      = 36;
   localparam int unsigned D_W      = 32;
   localparam int unsigned WORD_W   = 64;  // modular product width

   // Normalization target for the leading one.
   localparam logic [TOP_W-1:0] NORM_TOP = 6'd30;

   // Reciprocal square root constants, 30 fractional bits.
   localparam logic [29:0] GUESS_C0      = 30'd1053340729;
   localparam logic [28:0] GUESS_C1      = 29'd314491679;
   localparam logic [29:0] INV_SQRT2_Q30 = 30'd759250125;
   localparam logic [M_W-1:0]    HIGH_LIMIT = 32'h2000_0000;
   localparam logic [DIFF_W-1:0] ONE_Q30    = 33'h0_4000_0000;
   localparam logic [D_W-1:0]    THREE_Q30  = 32'hC000_0000;

   // Queue between the classifying front and the arithmetic back.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // One classified product as it waits in the queue.
   typedef struct packed {
      logic [NUM_COMP-1:0][ABS_W-1:0] mag;
      logic [NUM_COMP-1:0]            neg;
      logic                           zero;
      logic                           shift_left;
      logic [AMT_W-1:0]               shift_amt;
   } qmn_item_type;

   // Normalized magnitudes and signs carried alongside the root pipeline.
   typedef struct packed {
      logic [NUM_COMP-1:0][NORM_W-1:0] mag;
      logic [NUM_COMP-1:0]             neg;
      logic                            zero;
   } qmn_side_type;

   // Queue status seen by both sides.
   typedef struct packed {
      logic full;
      logic empty;
   } qmn_queue_status_type;

endpackage

[rtl/qmn_front.sv]
// Front end: accepts quaternion pairs, forms the product and classifies it.
module qmn_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [127:0]                  req_tdata,   // a_i, a_j, a_k, a_real, b_i, b_j, b_k, b_real
   output logic                          push,
   output qmn_pkg::qmn_item_type         push_item,
   input  qmn_pkg::qmn_queue_status_type queue_status
);

   localparam int unsigned NC = qmn_pkg::NUM_COMP;

   logic                                advance;
   logic [3:0]                          valid_ff;
   logic [3:0]                          valid_in;
   logic signed [qmn_pkg::COMP_W-1:0]   a [NC];
   logic signed [qmn_pkg::COMP_W-1:0]   b [NC];
   logic signed [qmn_pkg::PROD16_W-1:0] prod_ff [NC][NC];
   logic signed [qmn_pkg::PROD16_W-1:0] prod_in [NC][NC];
   logic signed [qmn_pkg::SUM_W-1:0]    comp_ff [NC];
   logic signed [qmn_pkg::SUM_W-1:0]    comp_in [NC];
   logic [qmn_pkg::ABS_W-1:0]           mag_ff [NC];
   logic [qmn_pkg::ABS_W-1:0]           mag_in [NC];
   logic [NC-1:0]                       neg_ff;
   logic [NC-1:0]                       neg_in;
   logic [qmn_pkg::ABS_W-1:0]           or_ff;
   logic [qmn_pkg::ABS_W-1:0]           or_in;
   qmn_pkg::qmn_item_type               item_ff;
   qmn_pkg::qmn_item_type               item_in;

   // The whole front moves when its last stage is empty or can enter the queue.
   assign advance    = !valid_ff[3] || !queue_status.full;
   assign req_tready = advance;
   assign push       = valid_ff[3] && !queue_status.full;
   assign push_item  = item_ff;

   // Unpack the transaction.
   always_comb begin
      for (int n = 0; n < NC; n++) begin
         a[n] = req_tdata[qmn_pkg::COMP_W*n +: qmn_pkg::COMP_W];
         b[n] = req_tdata[qmn_pkg::COMP_W*(n+NC) +: qmn_pkg::COMP_W];
      end
   end

   // Stage 1: the sixteen partial products, grouped by result component.
   always_comb begin
      prod_in[qmn_pkg::COMP_I][0] = a[qmn_pkg::COMP_REAL] * b[qmn_pkg::COMP_I];
      prod_in[qmn_pkg::COMP_I][1] = a[qmn_pkg::COMP_I]    * b[qmn_pkg::COMP_REAL];
      prod_in[qmn_pkg::COMP_I][2] = a[qmn_pkg::COMP_J]    * b[qmn_pkg::COMP_K];
      prod_in[qmn_pkg::COMP_I][3] = a[qmn_pkg::COMP_K]    * b[qmn_pkg::COMP_J];
      prod_in[qmn_pkg::COMP_J][0] = a[qmn_pkg::COMP_REAL] * b[qmn_pkg::COMP_J];
      prod_in[qmn_pkg::COMP_J][1] = a[qmn_pkg::COMP_J]    * b[qmn_pkg::COMP_REAL];
      prod_in[qmn_pkg::COMP_J][2] = a[qmn_pkg::COMP_K]    * b[qmn_pkg::COMP_I];
      prod_in[qmn_pkg::COMP_J][3] = a[qmn_pkg::COMP_I]    * b[qmn_pkg::COMP_K];
      prod_in[qmn_pkg::COMP_K][0] = a[qmn_pkg::COMP_REAL] * b[qmn_pkg::COMP_K];
      prod_in[qmn_pkg::COMP_K][1] = a[qmn_pkg::COMP_K]    * b[qmn_pkg::COMP_REAL];
      prod_in[qmn_pkg::COMP_K][2] = a[qmn_pkg::COMP_I]    * b[qmn_pkg::COMP_J];
      prod_in[qmn_pkg::COMP_K][3] = a[qmn_pkg::COMP_J]    * b[qmn_pkg::COMP_I];
      prod_in[qmn_pkg::COMP_REAL][0] = a[qmn_pkg::COMP_REAL] * b[qmn_pkg::COMP_REAL];
      prod_in[qmn_pkg::COMP_REAL][1] = a[qmn_pkg::COMP_I]    * b[qmn_pkg::COMP_I];
      prod_in[qmn_pkg::COMP_REAL][2] = a[qmn_pkg::COMP_J]    * b[qmn_pkg::COMP_J];
      prod_in[qmn_pkg::COMP_REAL][3] = a[qmn_pkg::COMP_K]    * b[qmn_pkg::COMP_K];
   end

   // Stage 2: Hamilton sums. The vector parts subtract their last term,
   // the scalar part subtracts all but the first.
   always_comb begin
      for (int k = 0; k < qmn_pkg::COMP_REAL; k++) begin
         comp_in[k] = qmn_pkg::SUM_W'(prod_ff[k][0]) + qmn_pkg::SUM_W'(prod_ff[k][1])
                    + qmn_pkg::SUM_W'(prod_ff[k][2]) - qmn_pkg::SUM_W'(prod_ff[k][3]);
      end
      comp_in[qmn_pkg::COMP_REAL] = qmn_pkg::SUM_W'(prod_ff[qmn_pkg::COMP_REAL][0])
                                  - qmn_pkg::SUM_W'(prod_ff[qmn_pkg::COMP_REAL][1])
                                  - qmn_pkg::SUM_W'(prod_ff[qmn_pkg::COMP_REAL][2])
                                  - qmn_pkg::SUM_W'(prod_ff[qmn_pkg::COMP_REAL][3]);
   end

   // Stage 3: sign and magnitude; the OR of the magnitudes has the same
   // leading one as their maximum.
   always_comb begin
      logic signed [qmn_pkg::SUM_W-1:0] abs_val;
      or_in = '0;
      for (int k = 0; k < NC; k++) begin
         neg_in[k] = comp_ff[k][qmn_pkg::SUM_W-1];
         abs_val   = neg_in[k] ? -comp_ff[k] : comp_ff[k];
         mag_in[k] = abs_val[qmn_pkg::ABS_W-1:0];
         or_in     = or_in | mag_in[k];
      end
   end

   // Stage 4: leading-one position and the shift that puts it at bit 30.
   always_comb begin
      logic [qmn_pkg::TOP_W-1:0] top;
      top = '0;
      for (int n = 0; n < qmn_pkg::ABS_W; n++) begin
         if (or_ff[n]) begin
            top = qmn_pkg::TOP_W'(n);
         end
      end
      for (int k = 0; k < NC; k++) begin
         item_in.mag[k] = mag_ff[k];
      end
      item_in.neg        = neg_ff;
      item_in.zero       = (or_ff == '0);
      item_in.shift_left = (top <= qmn_pkg::NORM_TOP);
      if (item_in.shift_left) begin
         item_in.shift_amt = qmn_pkg::AMT_W'(qmn_pkg::NORM_TOP - top);
      end else begin
         item_in.shift_amt = qmn_pkg::AMT_W'(top - qmn_pkg::NORM_TOP);
      end
   end

   // Valid bits travel with the data.
   assign valid_in = {valid_ff[2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         comp_ff <= comp_in;
         mag_ff  <= mag_in;
         neg_ff  <= neg_in;
         or_ff   <= or_in;
         item_ff <= item_in;
      end
   end

endmodule

[rtl/qmn_queue.sv]
// Short queue of classified products between the front and the back.
module qmn_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  qmn_pkg::qmn_item_type         push_item,
   input  logic                          pop,
   output qmn_pkg::qmn_item_type         pop_item,
   output qmn_pkg::qmn_queue_status_type queue_status
);

   qmn_pkg::qmn_item_type            entries_ff [qmn_pkg::QUEUE_DEPTH];
   logic [qmn_pkg::PTR_W-1:0]        wr_ptr_ff;
   logic [qmn_pkg::PTR_W-1:0]        wr_ptr_in;
   logic [qmn_pkg::PTR_W-1:0]        rd_ptr_ff;
   logic [qmn_pkg::PTR_W-1:0]        rd_ptr_in;
   logic [qmn_pkg::CNT_W-1:0]        count_ff;
   logic [qmn_pkg::CNT_W-1:0]        count_in;

   assign queue_status.empty = (count_ff == '0);
   assign queue_status.full  = (count_ff == qmn_pkg::CNT_W'(qmn_pkg::QUEUE_DEPTH));
   assign pop_item           = entries_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[rtl/qmn_newton.sv]
// One Newton refinement of the reciprocal square root, four pipeline stages.
module qmn_newton (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic [qmn_pkg::Y_W-1:0]       in_y,
   input  logic [qmn_pkg::M_W-1:0]       in_m,
   input  qmn_pkg::qmn_side_type         in_side,
   output logic                          out_valid,
   output logic [qmn_pkg::Y_W-1:0]       out_y,
   output logic [qmn_pkg::M_W-1:0]       out_m,
   output qmn_pkg::qmn_side_type         out_side
);

   localparam int unsigned YY_W = 2 * qmn_pkg::Y_W;
   localparam int unsigned MQ_W = qmn_pkg::M_W + qmn_pkg::Q_W;
   localparam int unsigned YD_W = qmn_pkg::Y_W + qmn_pkg::D_W;

   logic [3:0]                     valid_ff;
   logic [qmn_pkg::Y_W-1:0]        y_ff [4];
   logic [qmn_pkg::M_W-1:0]        m_ff [4];
   qmn_pkg::qmn_side_type          side_ff [4];
   logic [qmn_pkg::Q_W-1:0]        q_ff;
   logic [qmn_pkg::Q_W-1:0]        q_in;
   logic [qmn_pkg::E_W-1:0]        e_ff;
   logic [qmn_pkg::E_W-1:0]        e_in;
   logic [qmn_pkg::D_W-1:0]        d_ff;
   logic [qmn_pkg::D_W-1:0]        d_in;
   logic [qmn_pkg::Y_W-1:0]        y_new_in;
   logic [YY_W-1:0]                yy;
   logic [MQ_W-1:0]                mq;
   logic [YD_W-1:0]                yd;

   // All products keep their low 64 bits, as the arithmetic is modulo 2^64.
   // Stage a: q = (y*y) >> 30.
   assign yy   = YY_W'(in_y) * YY_W'(in_y);
   assign q_in = yy[63:30];

   // Stage b: e = (m*q) >> 28.
   assign mq   = MQ_W'(m_ff[0]) * MQ_W'(q_ff);
   assign e_in = mq[63:28];

   // Stage c: d = 3 - e, clamped at zero.
   assign d_in = (e_ff >= qmn_pkg::E_W'(qmn_pkg::THREE_Q30)) ? '0
               : qmn_pkg::D_W'(qmn_pkg::E_W'(qmn_pkg::THREE_Q30) - e_ff);

   // Stage d: y = (y*d) >> 31.
   assign yd       = YD_W'(y_ff[2]) * YD_W'(d_ff);
   assign y_new_in = qmn_pkg::Y_W'(yd[63:31]);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         q_ff       <= q_in;
         e_ff       <= e_in;
         d_ff       <= d_in;
         y_ff[0]    <= in_y;
         y_ff[1]    <= y_ff[0];
         y_ff[2]    <= y_ff[1];
         y_ff[3]    <= y_new_in;
         m_ff[0]    <= in_m;
         m_ff[1]    <= m_ff[0];
         m_ff[2]    <= m_ff[1];
         m_ff[3]    <= m_ff[2];
         side_ff[0] <= in_side;
         side_ff[1] <= side_ff[0];
         side_ff[2] <= side_ff[1];
         side_ff[3] <= side_ff[2];
      end
   end

   assign out_valid = valid_ff[3];
   assign out_y     = y_ff[3];
   assign out_m     = m_ff[3];
   assign out_side  = side_ff[3];

endmodule

[rtl/qmn_back.sv]
// Back end: normalizes, finds the reciprocal length, scales and rounds.
module qmn_back #(
   parameter int unsigned FRAC_BITS    = 14,
   parameter int unsigned NEWTON_STEPS = 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  qmn_pkg::qmn_queue_status_type queue_status,
   output logic                          pop,
   input  qmn_pkg::qmn_item_type         pop_item,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [63:0]                   rsp_tdata,   // p_i, p_j, p_k, p_real
   output logic                          rsp_tuser    // zero_length
);

   localparam int unsigned       NC         = qmn_pkg::NUM_COMP;
   localparam int unsigned       OUT_SHIFT  = 60 - FRAC_BITS;
   localparam logic [63:0]       ROUND_BIAS = 64'd1 << (59 - FRAC_BITS);
   localparam int unsigned       WIDE_W     = qmn_pkg::ABS_W + 30;
   localparam int unsigned       DC_W       = qmn_pkg::DIFF_W + 29;
   localparam int unsigned       UY_W       = qmn_pkg::NORM_W + qmn_pkg::Y_W;

   logic                                advance;
   logic [6:1]                          valid_ff;
   qmn_pkg::qmn_side_type               side_ff [6:1];
   qmn_pkg::qmn_side_type               s1_side_in;
   logic [qmn_pkg::SQ_W-1:0]            sq_ff [NC];
   logic [qmn_pkg::SQ_W-1:0]            sq_in [NC];
   logic [qmn_pkg::M_W-1:0]             m_ff [6:3];
   logic [qmn_pkg::M_W-1:0]             m_in;
   logic [5:4]                          high_ff;
   logic                                high_in;
   logic [qmn_pkg::T_W-1:0]             t_ff;
   logic [qmn_pkg::T_W-1:0]             t_in;
   logic signed [qmn_pkg::Y_W-1:0]      y0_ff;
   logic signed [qmn_pkg::Y_W-1:0]      y0_in;
   logic [qmn_pkg::Y_W-1:0]             yg_ff;
   logic [qmn_pkg::Y_W-1:0]             yg_in;
   logic [NEWTON_STEPS:0]               nt_valid;
   logic [qmn_pkg::Y_W-1:0]             nt_y [NEWTON_STEPS+1];
   logic [qmn_pkg::M_W-1:0]             nt_m [NEWTON_STEPS+1];
   qmn_pkg::qmn_side_type               nt_side [NEWTON_STEPS+1];
   logic                                p1_valid_ff;
   logic [qmn_pkg::WORD_W-1:0]          p1_prod_ff [NC];
   logic [qmn_pkg::WORD_W-1:0]          p1_prod_in [NC];
   logic [NC-1:0]                       p1_neg_ff;
   logic                                p1_zero_ff;
   logic                                rsp_tvalid_ff;
   logic [63:0]                         rsp_tdata_ff;
   logic [63:0]                         rsp_tdata_in;
   logic                                rsp_tuser_ff;

   // The back moves as a whole whenever the output register can take a result.
   assign advance = !rsp_tvalid_ff || rsp_tready;
   assign pop     = advance && !queue_status.empty;

   // Stage 1: move every leading one to bit 30 with one common shift.
   always_comb begin
      logic [WIDE_W-1:0] wide;
      for (int k = 0; k < NC; k++) begin
         if (pop_item.shift_left) begin
            wide = WIDE_W'(pop_item.mag[k]) << pop_item.shift_amt;
         end else begin
            wide = WIDE_W'(pop_item.mag[k]) >> pop_item.shift_amt;
         end
         s1_side_in.mag[k] = wide[qmn_pkg::NORM_W-1:0];
      end
      s1_side_in.neg  = pop_item.neg;
      s1_side_in.zero = pop_item.zero;
   end

   // Stage 2: squares of the normalized magnitudes.
   always_comb begin
      for (int k = 0; k < NC; k++) begin
         sq_in[k] = qmn_pkg::SQ_W'(side_ff[1].mag[k]) * qmn_pkg::SQ_W'(side_ff[1].mag[k]);
      end
   end

   // Stage 3: squared length; its upper word is the root argument.
   always_comb begin
      logic [qmn_pkg::WORD_W-1:0] len_sq;
      len_sq = '0;
      for (int k = 0; k < NC; k++) begin
         len_sq = len_sq + qmn_pkg::WORD_W'(sq_ff[k]);
      end
      m_in = len_sq[63:32];
   end

   // Stage 4: slope term of the linear first guess.
   always_comb begin
      logic [qmn_pkg::DIFF_W-1:0] w;
      logic [qmn_pkg::DIFF_W-1:0] diff;
      logic [DC_W-1:0]            slope;
      high_in = (m_ff[3] >= qmn_pkg::HIGH_LIMIT);
      w       = high_in ? {m_ff[3], 1'b0} : {m_ff[3][30:0], 2'b00};
      diff    = w - qmn_pkg::ONE_Q30;
      slope   = DC_W'(diff) * DC_W'(qmn_pkg::GUESS_C1);
      t_in    = slope[61:30];
   end

   // Stage 5: first guess; a large slope term wraps below zero as it would
   // in 64-bit unsigned arithmetic, so it is kept signed here.
   assign y0_in = $signed(qmn_pkg::Y_W'(qmn_pkg::GUESS_C0)) - $signed(qmn_pkg::Y_W'(t_ff));

   // Stage 6: scale by one over root two for arguments of two and above.
   always_comb begin
      logic signed [qmn_pkg::WORD_W-1:0] scaled;
      scaled = qmn_pkg::WORD_W'(y0_ff) * qmn_pkg::WORD_W'($signed({1'b0, qmn_pkg::INV_SQRT2_Q30}));
      yg_in  = high_ff[5] ? scaled[63:30] : y0_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[5:1], !queue_status.empty};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[1] <= s1_side_in;
         side_ff[2] <= side_ff[1];
         side_ff[3] <= side_ff[2];
         side_ff[4] <= side_ff[3];
         side_ff[5] <= side_ff[4];
         side_ff[6] <= side_ff[5];
         sq_ff      <= sq_in;
         m_ff[3]    <= m_in;
         m_ff[4]    <= m_ff[3];
         m_ff[5]    <= m_ff[4];
         m_ff[6]    <= m_ff[5];
         high_ff[4] <= high_in;
         high_ff[5] <= high_ff[4];
         t_ff       <= t_in;
         y0_ff      <= y0_in;
         yg_ff      <= yg_in;
      end
   end

   // Newton refinements, one four-stage unit each.
   assign nt_valid[0] = valid_ff[6];
   assign nt_y[0]     = yg_ff;
   assign nt_m[0]     = m_ff[6];
   assign nt_side[0]  = side_ff[6];

   for (genvar s = 0; s < NEWTON_STEPS; s++) begin : g_step
      qmn_newton u_newton (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (nt_valid[s]),
         .in_y      (nt_y[s]),
         .in_m      (nt_m[s]),
         .in_side   (nt_side[s]),
         .out_valid (nt_valid[s+1]),
         .out_y     (nt_y[s+1]),
         .out_m     (nt_m[s+1]),
         .out_side  (nt_side[s+1])
      );
   end

   // Product of each magnitude with the reciprocal length, low 64 bits.
   always_comb begin
      logic [UY_W-1:0] uy;
      for (int k = 0; k < NC; k++) begin
         uy            = UY_W'(nt_side[NEWTON_STEPS].mag[k]) * UY_W'(nt_y[NEWTON_STEPS]);
         p1_prod_in[k] = uy[qmn_pkg::WORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (advance) begin
         p1_valid_ff <= nt_valid[NEWTON_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p1_prod_ff <= p1_prod_in;
         p1_neg_ff  <= nt_side[NEWTON_STEPS].neg;
         p1_zero_ff <= nt_side[NEWTON_STEPS].zero;
      end
   end

   // Round half away from zero, apply the sign and saturate to 16 bits.
   always_comb begin
      logic [qmn_pkg::WORD_W-1:0] rounded;
      logic [qmn_pkg::WORD_W-1:0] mag;
      logic [15:0]                 comp;
      for (int k = 0; k < NC; k++) begin
         rounded = p1_prod_ff[k] + ROUND_BIAS;
         mag     = rounded >> OUT_SHIFT;
         if (p1_neg_ff[k]) begin
            comp = (mag > 64'd32768) ? 16'h8000 : 16'd0 - mag[15:0];
         end else begin
            comp = (mag > 64'd32767) ? 16'h7FFF : mag[15:0];
         end
         rsp_tdata_in[16*k +: 16] = p1_zero_ff ? 16'd0 : comp;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (advance) begin
         rsp_tvalid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= p1_zero_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

[rtl/quaternion_multiply_normalize.sv]
// Top level of the normalized quaternion product block.
// Each transaction on the req_ side carries two quaternions a and b in signed
// fixed point with FRAC_BITS fractional bits; the block returns the Hamilton
// product a*b scaled to unit length, rounded to nearest with ties away from
// zero, with rsp_tuser set and all components zero when the product is zero.
// One transaction is accepted per clock cycle while req_tready is high, and
// results come back in order. A transaction passes through four front stages
// that form and classify the product, the first of them loaded at the
// accepting edge, the four-entry queue, six stages of normalization and
// first guess, four stages for each Newton step, and two stages of scaling
// and rounding into the output register. A stalled response side holds the
// back end; the front keeps accepting until the queue is full.
`include "quaternion_multiply_normalize_assert.svh"

module quaternion_multiply_normalize #(
   parameter int unsigned FRAC_BITS    = 14,
   parameter int unsigned NEWTON_STEPS = 3
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // a_i, a_j, a_k, a_real, b_i, b_j, b_k, b_real
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,   // p_i, p_j, p_k, p_real
   output logic         rsp_tuser    // zero_length
);

   logic                          front_push;
   logic                          back_pop;
   qmn_pkg::qmn_item_type         push_item;
   qmn_pkg::qmn_item_type         pop_item;
   qmn_pkg::qmn_queue_status_type queue_status;

   // Product and classification.
   qmn_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .push         (front_push),
      .push_item    (push_item),
      .queue_status (queue_status)
   );

   // Decoupling queue.
   qmn_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (front_push),
      .push_item    (push_item),
      .pop          (back_pop),
      .pop_item     (pop_item),
      .queue_status (queue_status)
   );

   // Normalization, reciprocal root and rounding.
   qmn_back #(
      .FRAC_BITS    (FRAC_BITS),
      .NEWTON_STEPS (NEWTON_STEPS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .pop          (back_pop),
      .pop_item     (pop_item),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser)
   );

   // Queue discipline and zero-length results.
   `QMN_ASSERT_IMPLY(a_push_not_full, front_push, !queue_status.full, "push into a full queue")
   `QMN_ASSERT_IMPLY(a_pop_not_empty, back_pop, !queue_status.empty, "pop from an empty queue")
   `QMN_ASSERT_NEXT(a_push_fills, front_push && !back_pop, !queue_status.empty, "pushed item lost")
   `QMN_ASSERT_IMPLY(a_zero_output, rsp_tvalid && rsp_tuser, rsp_tdata == '0, "zero length not zero")

endmodule
